// ===== rtl/core/dsrl_pkg.sv =====
// dsrl_pkg: shared types and constants of the descending sorted record list
// used by the controller, the datapath, the top level and the port checker
// no dependencies
package dsrl_pkg;

    // stream widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 3;

    // operation codes carried on s_tuser
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LIST   = 2'd1;
    localparam logic [1:0] FUNC_HIGH   = 2'd2;

    // result status codes carried on m_tuser[1:0]
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // one stored record, amount in the lowest bits
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] budget;
        logic [11:0] year;
        logic [31:0] amount;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // what the output register is loaded with
    typedef enum logic [1:0] {
        SEL_DONE,
        SEL_EMPTY,
        SEL_FULL,
        SEL_REC
    } out_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     latch;
        logic     insert;
        logic     load;
        out_sel_t sel;
        logic     force_last;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       full;
        logic       empty;
        logic       idx_last;
        logic       out_last;
    } dp_status_t;

endpackage

// ===== rtl/core/dsrl_datapath.sv =====
// dsrl_datapath: chain of record cells with parallel compare for sorted insert,
// read index for listing and the result register
// depends on dsrl_pkg
module dsrl_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [dsrl_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [dsrl_pkg::S_TUSER_W-1:0]    s_tuser,
    input  dsrl_pkg::dp_cmd_t                 cmd,
    output dsrl_pkg::dp_status_t              status,
    output logic [dsrl_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [dsrl_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tlast
);
    import dsrl_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    rec_t               in_rec_reg;
    logic [1:0]         func_reg;
    rec_t               cells_reg [CAPACITY];
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    rec_t               out_rec_reg;
    logic [1:0]         out_status_reg;
    logic               out_has_reg;
    logic               out_last_reg;

    logic [CAPACITY-1:0] go;
    logic [CAPACITY-1:0] go_prev;
    logic                full;
    logic                empty;
    logic                idx_last;

    // latched transaction fields
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            in_rec_reg <= rec_t'(s_tdata[REC_W-1:0]);
            func_reg   <= s_tuser[1:0];
        end
    end

    // a cell takes part in the insert from the first stored amount that is
    // not larger than the new one, or from the first free cell
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            go[i] = (cells_reg[i].amount <= in_rec_reg.amount) ||
                    (CNT_W'(i) >= count_reg);
        end
        go_prev = {go[CAPACITY-2:0], 1'b0};
    end

    // cell chain: the first active cell loads the new record, the rest shift down
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            always_ff @(posedge aclk) begin
                if (cmd.insert && go[g]) begin
                    cells_reg[g] <= in_rec_reg;
                end
            end
        end else begin : g_body
            always_ff @(posedge aclk) begin
                if (cmd.insert && go[g]) begin
                    if (go_prev[g]) begin
                        cells_reg[g] <= cells_reg[g-1];
                    end else begin
                        cells_reg[g] <= in_rec_reg;
                    end
                end
            end
        end
    end

    // record count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.insert) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // read index for listing
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            idx_reg <= '0;
        end else if (cmd.load && cmd.sel == SEL_REC) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            unique case (cmd.sel)
                SEL_DONE: begin
                    out_rec_reg    <= '0;
                    out_status_reg <= STATUS_OK;
                    out_has_reg    <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
                SEL_EMPTY: begin
                    out_rec_reg    <= '0;
                    out_status_reg <= STATUS_EMPTY;
                    out_has_reg    <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
                SEL_FULL: begin
                    out_rec_reg    <= '0;
                    out_status_reg <= STATUS_FULL;
                    out_has_reg    <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
                SEL_REC: begin
                    out_rec_reg    <= cells_reg[idx_reg];
                    out_status_reg <= STATUS_OK;
                    out_has_reg    <= 1'b1;
                    out_last_reg   <= cmd.force_last | idx_last;
                end
                default: begin
                    out_rec_reg    <= '0;
                    out_status_reg <= STATUS_OK;
                    out_has_reg    <= 1'b0;
                    out_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign status.func     = func_reg;
    assign status.full     = full;
    assign status.empty    = empty;
    assign status.idx_last = idx_last;
    assign status.out_last = out_last_reg;

    assign m_tdata = {(M_TDATA_W - REC_W)'(0), out_rec_reg};
    assign m_tuser = {out_has_reg, out_status_reg};
    assign m_tlast = out_last_reg;

endmodule

// ===== rtl/core/dsrl_controller.sv =====
// dsrl_controller: state machine that sequences insert, list and highest
// operations and owns both handshakes
// depends on dsrl_pkg
module dsrl_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  dsrl_pkg::dp_status_t status,
    output dsrl_pkg::dp_cmd_t    cmd
);
    import dsrl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    // next state and datapath commands
    always_comb begin
        state_next     = state_reg;
        m_tvalid_next  = m_tvalid_reg;
        cmd.latch      = 1'b0;
        cmd.insert     = 1'b0;
        cmd.load       = 1'b0;
        cmd.sel        = SEL_DONE;
        cmd.force_last = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (status.func)
                    FUNC_INSERT: begin
                        cmd.load      = 1'b1;
                        cmd.insert    = !status.full;
                        cmd.sel       = status.full ? SEL_FULL : SEL_DONE;
                        m_tvalid_next = 1'b1;
                        state_next    = ST_SEND;
                    end
                    FUNC_LIST, FUNC_HIGH: begin
                        cmd.load       = 1'b1;
                        cmd.sel        = status.empty ? SEL_EMPTY : SEL_REC;
                        cmd.force_last = (status.func == FUNC_HIGH);
                        m_tvalid_next  = 1'b1;
                        state_next     = ST_SEND;
                    end
                    default: begin
                        // unused code, no result
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SEND: begin
                if (m_tready) begin
                    if (status.out_last) begin
                        m_tvalid_next = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        cmd.load = 1'b1;
                        cmd.sel  = SEL_REC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== rtl/core/descending_sorted_record_list.sv =====
// descending_sorted_record_list: top level of the sorted record list
// instantiates dsrl_controller and dsrl_datapath, depends on dsrl_pkg
//
// Usage:
//   s_ channel takes one operation per transaction: s_tuser carries the
//   operation (insert, list all, report highest), s_tdata the record for
//   an insert. m_ channel returns results: m_tuser carries status and the
//   record-present flag, m_tdata the record, m_tlast marks the final
//   result of an operation.
//   The result register is loaded in the cycle after the input
//   transaction is accepted.
//   An insert or highest steps through accept, execute in the cell chain
//   and deliver; a list delivers one record per cycle out of the cell
//   chain read port while m_tready is held high.
//   A new operation is accepted only after the last result is taken.
//   The insert is done by a parallel compare in every cell, all cells updating in the same cycle.
//   Reset clears the record count, the state and the result valid flag;
//   no clearing pass.
//   When the receiver stalls, the result register holds and s_tready stays
//   low until the final result of the current operation is taken.
module descending_sorted_record_list #(
    parameter int CAPACITY = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // amount[31:0], year[43:32], budget[75:44], record_tag[91:76], zero pad
    input  logic [dsrl_pkg::S_TDATA_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [dsrl_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_amount[31:0], out_year[43:32], out_budget[75:44], out_tag[91:76], zero pad
    output logic [dsrl_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[1:0], has_record[2]
    output logic [dsrl_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tlast
);
    import dsrl_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing
    dsrl_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // cell chain and result register
    dsrl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ===== rtl/core/dsrl_checker.sv =====
// dsrl_checker: port-level assertions for the sorted record list
// bound to descending_sorted_record_list, depends on dsrl_pkg
module dsrl_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [dsrl_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [dsrl_pkg::M_TUSER_W-1:0]    m_tuser,
    input logic                              m_tlast
);
    import dsrl_pkg::*;

    // one operation at a time: no intake while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // the execute cycle separates an input transaction from its first result
    a_exec_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result shown in the execute cycle");

    // a status-only result always ends its operation
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[2]) |-> m_tlast)
        else $error("status result without last");

    // no record means zero record fields
    a_no_rec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[2]) |-> (m_tdata == '0))
        else $error("record fields set without a record");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed under stall");

endmodule

bind descending_sorted_record_list dsrl_checker u_dsrl_checker (.*);

// ===== tb/dsrl_scoreboard.sv =====
// dsrl_scoreboard: watches both stream channels of the sorted record list,
// keeps its own copy of the list, predicts every result and compares them
// depends on dsrl_pkg for the record layout, operation and status codes
module dsrl_scoreboard #(
    parameter int CAPACITY = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [dsrl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [dsrl_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dsrl_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [dsrl_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                           m_tlast,
    output int                             error_count,
    output int                             pending_count,
    output int                             result_count,
    output int                             drop_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import dsrl_pkg::*;

    // one predicted result transaction
    typedef struct packed {
        logic [1:0] status;
        logic       has_rec;
        rec_t       rec;
        logic       last;
    } list_result_t;

    // shadow copy of the sorted list, head at index zero
    rec_t         sorted_recs [CAPACITY];
    int           sorted_len = 0;
    list_result_t awaited_results [$];

    initial begin
        error_count   = 0;
        pending_count = 0;
        result_count  = 0;
        drop_count    = 0;
    end

    function automatic list_result_t make_result(logic [1:0] status, logic has_rec,
                                                 rec_t rec, logic last);
        list_result_t res;
        res.status  = status;
        res.has_rec = has_rec;
        res.rec     = has_rec ? rec : '0;
        res.last    = last;
        return res;
    endfunction

    // update the shadow list with one operation and queue what it returns
    task automatic apply_operation(logic [1:0] func, rec_t in_rec);
        int pos;
        case (func)
            FUNC_INSERT: begin
                if (sorted_len >= CAPACITY) begin
                    awaited_results.push_back(make_result(STATUS_FULL, 1'b0, '0, 1'b1));
                    drop_count++;
                end else begin
                    // new record goes ahead of the first one not larger
                    pos = sorted_len;
                    for (int i = 0; i < sorted_len; i++) begin
                        if (sorted_recs[i].amount <= in_rec.amount) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = sorted_len; i > pos; i--)
                        sorted_recs[i] = sorted_recs[i-1];
                    sorted_recs[pos] = in_rec;
                    sorted_len++;
                    awaited_results.push_back(make_result(STATUS_OK, 1'b0, '0, 1'b1));
                end
            end
            FUNC_LIST, FUNC_HIGH: begin
                if (sorted_len == 0) begin
                    awaited_results.push_back(make_result(STATUS_EMPTY, 1'b0, '0, 1'b1));
                end else if (func == FUNC_HIGH) begin
                    awaited_results.push_back(make_result(STATUS_OK, 1'b1, sorted_recs[0],
                                                          1'b1));
                end else begin
                    for (int i = 0; i < sorted_len; i++)
                        awaited_results.push_back(make_result(STATUS_OK, 1'b1, sorted_recs[i],
                                                              i == sorted_len - 1));
                end
            end
            default: ; // unused code, ignored by the block
        endcase
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
            error_count++;
        end
    endtask

    // compare result transactions first, then take in new operations
    always @(posedge aclk) begin
        list_result_t want;
        rec_t         got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                result_count++;
                got = m_tdata[REC_W-1:0];
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual status %0d tdata 0x%0h",
                             $time, m_tuser[1:0], m_tdata);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status",     want.status,      m_tuser[1:0]);
                    check_field("has_record", want.has_rec,     m_tuser[2]);
                    check_field("out_amount", want.rec.amount,  got.amount);
                    check_field("out_year",   want.rec.year,    got.year);
                    check_field("out_budget", want.rec.budget,  got.budget);
                    check_field("out_tag",    want.rec.tag,     got.tag);
                    check_field("last",       want.last,        m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                apply_operation(s_tuser, s_tdata[REC_W-1:0]);
        end
        pending_count = awaited_results.size();
    end

endmodule

// ===== tb/tb_descending_sorted_record_list.sv =====
// tb_descending_sorted_record_list: drives operations into the sorted record
// list with random gaps and receiver stalls, verdict from dsrl_scoreboard
// depends on dsrl_pkg, descending_sorted_record_list and dsrl_scoreboard
module tb_descending_sorted_record_list;
    timeunit 1ns;
    timeprecision 1ps;
    import dsrl_pkg::*;

    localparam int         LIST_CAPACITY = 16;
    localparam int         RANDOM_OPS    = 270;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    int          error_count;
    int          pending_count;
    int          result_count;
    int          drop_count;
    int          op_count   = 0;
    logic [15:0] cycle_cnt  = '0;
    int          ready_hold = 0;
    logic        calm_window;

    descending_sorted_record_list #(
        .CAPACITY (LIST_CAPACITY)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dsrl_scoreboard #(
        .CAPACITY (LIST_CAPACITY)
    ) u_scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .pending_count (pending_count),
        .result_count  (result_count),
        .drop_count    (drop_count)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // periodic windows in which no new sender gaps or receiver stalls begin
    assign calm_window = (cycle_cnt[8:6] == 3'd0);

    // receiver stalls: mostly short, a few long
    always @(posedge aclk) begin
        int roll;
        cycle_cnt <= cycle_cnt + 1'b1;
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm_window) begin
            m_tready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end else if (roll < 92) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(12, 45);
            end
        end
    end

    // one operation transaction, preceded by a random idle gap
    task automatic send_op(logic [1:0] func, logic [31:0] amount, logic [11:0] year,
                           logic [31:0] budget, logic [15:0] tag);
        int   gap;
        int   roll;
        rec_t rec;
        roll = $urandom_range(0, 99);
        if (calm_window || roll < 60)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(12, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        rec.amount = amount;
        rec.year   = year;
        rec.budget = budget;
        rec.tag    = tag;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(S_TDATA_W-REC_W){1'b0}}, rec};
        do @(posedge aclk); while (!s_tready);
        op_count++;
    endtask

    // watchdog
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int          counted;
        int          roll;
        logic [1:0]  func;
        logic [31:0] amount;
        counted = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty list, unused code, extreme records, equal amounts
        send_op(FUNC_HIGH,   '0, '0, '0, '0);
        send_op(FUNC_LIST,   '1, '1, '1, '1);
        send_op(FUNC_UNUSED, '0, '0, '0, '0);
        send_op(FUNC_INSERT, '0, '0, '0, '0);
        send_op(FUNC_INSERT, '1, '1, '1, '1);
        send_op(FUNC_INSERT, '1, 12'h5A5, 32'h1234_5678, 16'hBEEF);
        send_op(FUNC_INSERT, '0, 12'hA5A, 32'hFEDC_BA98, 16'h0001);
        send_op(FUNC_INSERT, 32'h8000_0000, 12'h800, 32'h8000_0000, 16'h8000);
        send_op(FUNC_LIST,   '0, '0, '0, '0);
        send_op(FUNC_HIGH,   '0, '0, '0, '0);
        send_op(FUNC_UNUSED, '1, '1, '1, '1);
        send_op(FUNC_INSERT, 32'h7FFF_FFFF, 12'h7FF, 32'h7FFF_FFFF, 16'h7FFF);
        send_op(FUNC_LIST,   '0, '0, '0, '0);

        // random mix; inserts with many ties until full, then dropped ones
        while (counted < RANDOM_OPS) begin
            roll = $urandom_range(0, 99);
            if (roll < 38)
                func = FUNC_INSERT;
            else if (roll < 66)
                func = FUNC_LIST;
            else if (roll < 94)
                func = FUNC_HIGH;
            else
                func = FUNC_UNUSED;
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                case ($urandom_range(0, 3))
                    0:       amount = '0;
                    1:       amount = '1;
                    2:       amount = 32'h8000_0000;
                    default: amount = 32'h7FFF_FFFF;
                endcase
            end else if (roll < 45) begin
                amount = $urandom_range(0, 7);
            end else begin
                amount = $urandom;
            end
            send_op(func, amount, 12'($urandom), $urandom, 16'($urandom));
            if (func != FUNC_UNUSED)
                counted++;
        end
        s_tvalid <= 1'b0;

        // drain, then a short tail for stray results
        do @(posedge aclk); while (pending_count != 0);
        repeat (20) @(posedge aclk);

        $display("covered %0d operations including unused codes, %0d results checked",
                 op_count, result_count);
        $display("%0d inserts were dropped on a full list", drop_count);
        if (error_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
